FILE: rtl/fbe_pkg.sv
// Shared types, constants and key schedule for the Feistel block encryptor.
package fbe_pkg;

    localparam int HALF_W = 32;

    localparam logic [HALF_W-1:0] KEY_STRIDE = 32'h0101_0101;
    localparam logic [HALF_W-1:0] KEY_MUL    = 32'd13;
    localparam logic [HALF_W-1:0] KEY_OFFSET = 32'h37;
    localparam logic [HALF_W-1:0] F_MUL      = 32'h1F;
    localparam int                ROT_LEFT   = 3;
    localparam int                ROT_RIGHT  = 29;

    // One pipeline slot: a block of two halves plus its valid bit.
    typedef struct packed {
        logic              valid;
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } stage_t;

    // Round key, evaluated at elaboration from the round index.
    function automatic logic [HALF_W-1:0] round_key(input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] a;
        logic [HALF_W-1:0] b;
        a = k * KEY_STRIDE;
        b = k * KEY_MUL + KEY_OFFSET;
        return a ^ b;
    endfunction

endpackage

FILE: rtl/fbe_round.sv
// One registered Feistel round stage with a fixed round key.
module fbe_round #(
    parameter int ROUND_IDX = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  fbe_pkg::stage_t d,
    output fbe_pkg::stage_t q
);

    localparam logic [fbe_pkg::HALF_W-1:0] KEY =
        fbe_pkg::round_key(fbe_pkg::HALF_W'(ROUND_IDX));

    logic [fbe_pkg::HALF_W-1:0] mixed;
    logic [fbe_pkg::HALF_W-1:0] rot;
    logic [fbe_pkg::HALF_W-1:0] f_val;
    fbe_pkg::stage_t            stage_reg;
    fbe_pkg::stage_t            stage_next;

    // F(r, K) = rotl(r ^ K, 3) + 31 * r, all mod 2^32
    always_comb begin
        mixed            = d.right ^ KEY;
        rot              = (mixed << fbe_pkg::ROT_LEFT) | (mixed >> fbe_pkg::ROT_RIGHT);
        f_val            = rot + d.right * fbe_pkg::F_MUL;
        stage_next.valid = d.valid;
        stage_next.left  = d.right;
        stage_next.right = d.left ^ f_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg.valid <= stage_next.valid;
        end
        if (advance) begin
            stage_reg.left  <= stage_next.left;
            stage_reg.right <= stage_next.right;
        end
    end

    assign q = stage_reg;

endmodule

FILE: rtl/feistel_block_encrypt.sv
// Top level of the pipelined 64-bit Feistel block encryptor.
//
// Encrypts one 64-bit block per word through ROUNDS Feistel rounds, one
// registered round per pipeline stage. A new block can be taken every clock
// cycle while the output side does not stall; each block passes through the
// round registers in order. The last round stage is the output register. When
// the output word is held (m_tvalid high, m_tready low) the whole pipeline
// freezes and s_tready drops, so nothing is dropped or duplicated. Reset
// clears only the per-stage valid bits; the data halves are not reset.
module feistel_block_encrypt #(
    parameter int ROUNDS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] left_in, [63:32] right_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] left_out, [63:32] right_out
);

    localparam int W = fbe_pkg::HALF_W;

    fbe_pkg::stage_t   stg [ROUNDS+1];
    logic              advance;
    logic [ROUNDS-1:0] vld;

    // pipeline moves unless the output word is stuck
    assign advance  = !(stg[ROUNDS].valid && !m_tready);
    assign s_tready = advance;

    assign stg[0].valid = s_tvalid;
    assign stg[0].left  = s_tdata[W-1:0];
    assign stg[0].right = s_tdata[2*W-1:W];

    for (genvar i = 0; i < ROUNDS; i++) begin : g_round
        fbe_round #(
            .ROUND_IDX(i)
        ) u_round (
            .aclk   (aclk),
            .aresetn(aresetn),
            .advance(advance),
            .d      (stg[i]),
            .q      (stg[i+1])
        );
        assign vld[i] = stg[i+1].valid;
    end

    assign m_tvalid = stg[ROUNDS].valid;
    assign m_tdata  = {stg[ROUNDS].right, stg[ROUNDS].left};

    // accepted word lands in the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld[0])
        else $error("accepted word missing from first stage");

    // a stall freezes every valid bit
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld))
        else $error("pipeline moved during stall");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

FILE: test/feistel_block_encrypt_tb.sv
// Testbench for feistel_block_encrypt: directed and random words, checked against a predictor.
`timescale 1ns / 100ps

module feistel_block_encrypt_tb;

    localparam int HALF_W       = fbe_pkg::HALF_W;
    localparam int ROUNDS       = 32;
    localparam int RANDOM_WORDS = 1800;
    localparam int IDLE_PCT     = 6;
    localparam int CYCLE_LIMIT  = 200000;

    // One 64-bit block as its two halves.
    typedef struct packed {
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } block_t;

    // Directed plaintexts: field extremes, single bits, alternating patterns.
    // Ciphertexts are not obvious by eye, so every row goes through the predictor.
    localparam int DIRECTED_ROWS = 14;
    localparam block_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{32'h0000_0000, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{32'h0000_0000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h0000_0000},
        '{32'h0000_0001, 32'h0000_0000},
        '{32'h0000_0000, 32'h0000_0001},
        '{32'h8000_0000, 32'h8000_0000},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{32'hAAAA_AAAA, 32'h5555_5555},
        '{32'h5555_5555, 32'hAAAA_AAAA},
        '{32'hE000_0000, 32'h0000_0007},   // bits that wrap in the rotate
        '{32'h0842_1084, 32'h0842_1084},   // product by 31 carries far
        '{32'h0123_4567, 32'h89AB_CDEF},
        '{32'hDEAD_BEEF, 32'hCAFE_F00D}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // [31:0] left_in, [63:32] right_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [31:0] left_out, [63:32] right_out

    block_t      expected_cipher[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          steady_run     = 1'b0;   // no idling on either side while set

    feistel_block_encrypt #(.ROUNDS(ROUNDS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Full ROUNDS-round Feistel pass over one block.
    function automatic block_t cipher_model(input logic [HALF_W-1:0] l_in,
                                            input logic [HALF_W-1:0] r_in);
        logic [HALF_W-1:0] lhs;
        logic [HALF_W-1:0] rhs;
        logic [HALF_W-1:0] key;
        logic [HALF_W-1:0] mixed;
        logic [HALF_W-1:0] mix_fn;
        logic [HALF_W-1:0] k;
        block_t            res;
        lhs = l_in;
        rhs = r_in;
        for (int i = 0; i < ROUNDS; i++) begin
            k      = HALF_W'(i);
            key    = (k * fbe_pkg::KEY_STRIDE) ^ (k * fbe_pkg::KEY_MUL + fbe_pkg::KEY_OFFSET);
            mixed  = rhs ^ key;
            mix_fn = (mixed << fbe_pkg::ROT_LEFT) | (mixed >> fbe_pkg::ROT_RIGHT);
            mix_fn = mix_fn + rhs * fbe_pkg::F_MUL;
            mixed  = lhs ^ mix_fn;
            lhs    = rhs;
            rhs    = mixed;
        end
        res.left  = lhs;
        res.right = rhs;
        return res;
    endfunction

    // Random half, biased toward extremes and single-bit patterns.
    function automatic logic [HALF_W-1:0] pick_half();
        logic [HALF_W-1:0] one_bit;
        one_bit = 32'h1 << $urandom_range(HALF_W-1);
        case ($urandom_range(9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return one_bit;
            end
            3: begin
                return ~one_bit;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Offer one word, with random idle cycles ahead of it; the expectation
    // is queued on the edge that takes the word.
    task automatic send_block(input block_t blk);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blk.right, blk.left};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_cipher.push_back(cipher_model(blk.left, blk.right));
    endtask

    // Hold off the sender until the pipeline has emptied. Always waits for a
    // clock edge before returning, so tvalid is never lowered and raised in one step.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_cipher.size() != 0);
    endtask

    // Output side stalls at random, except during the steady stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checker: each taken word against the oldest expectation.
    always @(posedge aclk) begin
        block_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cipher.size() == 0) begin
                $error("unexpected word: m_tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_cipher.pop_front();
                if (m_tdata[31:0] !== want.left) begin
                    $error("left_out: expected %h, actual %h", want.left, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[63:32] !== want.right) begin
                    $error("right_out: expected %h, actual %h", want.right, m_tdata[63:32]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        block_t blk;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_block(DIRECTED[i]);
        end
        drain_pipeline();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            steady_run = (i >= 700 && i < 1100);
            if (i == 1300) begin
                drain_pipeline();
            end
            blk.left  = pick_half();
            blk.right = pick_half();
            send_block(blk);
        end
        steady_run = 1'b0;

        drain_pipeline();
        repeat (4 * ROUNDS) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
